@@ rtl/rcd_pkg.sv @@
// Package for the RC receiver PPM/PWM pulse decoder.
// Holds sizes, opcode and register index codes and the transaction payload types.
// Used by the channel interfaces and the decoder top level; depends on nothing.
`default_nettype none

package rcd_pkg;

    // Sizes of the channel store and the port table.
    localparam int NUM_CHANNELS    = 8;
    localparam int NUM_INPUT_PORTS = 8;

    // Field widths fixed by the item format.
    localparam int TS_W   = 16;
    localparam int PORT_W = 3;
    localparam int CH_W   = 3;

    // Index width into the channel store and width of the PPM channel counter,
    // which has to hold NUM_CHANNELS itself.
    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PORT_IDX_W = (NUM_INPUT_PORTS > 1) ? $clog2(NUM_INPUT_PORTS) : 1;
    localparam int CNT_W      = $clog2(NUM_CHANNELS + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_CHANNELS);

    // Opcodes of an input transaction.
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PPM_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP  = 2'd3;

    // Configuration values after reset.
    localparam logic            RST_PPM_MODE  = 1'b1;
    localparam logic [TS_W-1:0] RST_PULSE_MIN = 16'd750;
    localparam logic [TS_W-1:0] RST_PULSE_MAX = 16'd2250;
    localparam logic [TS_W-1:0] RST_SYNC_GAP  = 16'd2700;

    // Input transaction: a capture event or a read of the store.
    typedef struct packed {
        logic              opcode;
        logic [PORT_W-1:0] port;
        logic [TS_W-1:0]   timestamp;
        logic [CH_W-1:0]   read_channel;
    } req_t;

    // Result transaction.
    typedef struct packed {
        logic [TS_W-1:0] read_value;
        logic            arm_falling;
        logic            stored;
        logic [CH_W-1:0] stored_index;
        logic            frame_sync;
    } rsp_t;

endpackage

`default_nettype wire

@@ rtl/rcd_req_if.sv @@
// Valid/ready channel that carries input transactions into the decoder.
// Depends on rcd_pkg for the payload type.
`default_nettype none

interface rcd_req_if;
    logic          valid;
    logic          ready;
    rcd_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/rcd_rsp_if.sv @@
// Valid/ready channel that carries result transactions out of the decoder.
// Depends on rcd_pkg for the payload type.
`default_nettype none

interface rcd_rsp_if;
    logic          valid;
    logic          ready;
    rcd_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/rc_ppm_pwm_input_decoder_top.sv @@
// Top level of the RC receiver PPM/PWM pulse decoder.
// Depends on rcd_pkg, rcd_req_if and rcd_rsp_if.
`default_nettype none

// The decoder takes one transaction per clock cycle while the result side does not
// stall and returns exactly one result for each, via the input register and then the
// result register. A transaction lands in the input register; the working stage does
// a single subtract of the timestamp against the stored previous time (PPM) or the
// port's rise time (PWM), followed by the window and sync compares, updates the decoder
// state and loads the result register. Because state is read and written in that same
// stage, back-to-back captures see each other's effects without any stall. Backpressure
// on the result channel stalls both registers; the channel store is cleared at reset
// and a read transaction returns the width last written to the requested channel.
module rc_ppm_pwm_input_decoder_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    rcd_req_if.sink                             req,
    rcd_rsp_if.source                           rsp,
    input  wire logic                           cfg_we,
    input  wire logic [rcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rcd_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic                      ppm_mode_reg;
    logic [rcd_pkg::TS_W-1:0]  pulse_min_reg;
    logic [rcd_pkg::TS_W-1:0]  pulse_max_reg;
    logic [rcd_pkg::TS_W-1:0]  sync_gap_reg;

    // Decoder state.
    logic [rcd_pkg::TS_W-1:0]  width_reg [rcd_pkg::NUM_CHANNELS];
    logic [rcd_pkg::TS_W-1:0]  prev_time_reg;
    logic [rcd_pkg::CNT_W-1:0] ppm_cnt_reg;
    logic [rcd_pkg::CNT_W-1:0] ppm_cnt_next;
    logic [rcd_pkg::NUM_INPUT_PORTS-1:0] phase_reg;
    logic [rcd_pkg::NUM_INPUT_PORTS-1:0] phase_next;
    logic [rcd_pkg::TS_W-1:0]  rise_reg [rcd_pkg::NUM_INPUT_PORTS];

    // Pipeline registers.
    logic           in_valid_reg;
    rcd_pkg::req_t  in_reg;
    logic           out_valid_reg;
    rcd_pkg::rsp_t  out_reg;
    rcd_pkg::rsp_t  out_next;

    logic advance;

    // Decode signals of the working stage.
    logic                        is_capture;
    logic                        ppm_cap;
    logic                        pwm_cap;
    logic                        port_ok;
    logic                        port_has_ch;
    logic [rcd_pkg::PORT_IDX_W-1:0] port_idx;
    logic [rcd_pkg::CH_IDX_W-1:0]   port_ch;
    logic [rcd_pkg::CH_IDX_W-1:0]   cnt_ch;
    logic                        cnt_open;
    logic [rcd_pkg::TS_W-1:0]    delta;
    logic                        in_window;
    logic                        is_sync;
    logic                        rise_wr;
    logic                        wr_en;
    logic [rcd_pkg::CH_IDX_W-1:0] wr_idx;

    // Handshake: the input register moves on when the result register is free or
    // is being drained in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppm_mode_reg  <= rcd_pkg::RST_PPM_MODE;
            pulse_min_reg <= rcd_pkg::RST_PULSE_MIN;
            pulse_max_reg <= rcd_pkg::RST_PULSE_MAX;
            sync_gap_reg  <= rcd_pkg::RST_SYNC_GAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcd_pkg::REG_PPM_MODE:  ppm_mode_reg  <= cfg_data[0];
                rcd_pkg::REG_PULSE_MIN: pulse_min_reg <= cfg_data;
                rcd_pkg::REG_PULSE_MAX: pulse_max_reg <= cfg_data;
                rcd_pkg::REG_SYNC_GAP:  sync_gap_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req.payload;
        end
    end

    // Working stage: a single subtract and the compares that follow it.
    always_comb
    begin
        is_capture  = (in_reg.opcode == rcd_pkg::OP_CAPTURE);
        ppm_cap     = is_capture && ppm_mode_reg;
        port_ok     = ({1'b0, in_reg.port} < (rcd_pkg::PORT_W + 1)'(rcd_pkg::NUM_INPUT_PORTS));
        port_has_ch = ({1'b0, in_reg.port} < (rcd_pkg::PORT_W + 1)'(rcd_pkg::NUM_CHANNELS));
        pwm_cap     = is_capture && !ppm_mode_reg && port_ok;
        port_idx    = in_reg.port[rcd_pkg::PORT_IDX_W-1:0];
        port_ch     = in_reg.port[rcd_pkg::CH_IDX_W-1:0];
        cnt_ch      = ppm_cnt_reg[rcd_pkg::CH_IDX_W-1:0];
        cnt_open    = (ppm_cnt_reg < rcd_pkg::CNT_MAX);

        // PPM measures against the previous capture, PWM against the port's rise.
        if (ppm_mode_reg)
        begin
            delta = in_reg.timestamp - prev_time_reg;
        end
        else
        begin
            delta = in_reg.timestamp - rise_reg[port_idx];
        end
        in_window = (delta > pulse_min_reg) && (delta < pulse_max_reg);
        is_sync   = ppm_cap && (delta > sync_gap_reg);

        ppm_cnt_next = ppm_cnt_reg;
        phase_next   = phase_reg;
        rise_wr      = 1'b0;
        wr_en        = 1'b0;
        wr_idx       = port_ch;
        out_next     = '0;

        if (!is_capture)
        begin
            // Read of the store.
            if ({1'b0, in_reg.read_channel} < (rcd_pkg::CH_W + 1)'(rcd_pkg::NUM_CHANNELS))
            begin
                out_next.read_value = width_reg[in_reg.read_channel[rcd_pkg::CH_IDX_W-1:0]];
            end
        end
        else if (ppm_cap)
        begin
            if (is_sync)
            begin
                ppm_cnt_next        = '0;
                out_next.frame_sync = 1'b1;
            end
            else if (cnt_open)
            begin
                ppm_cnt_next = ppm_cnt_reg + 1'b1;
                if (in_window)
                begin
                    wr_en                 = 1'b1;
                    wr_idx                = cnt_ch;
                    out_next.stored       = 1'b1;
                    out_next.stored_index = rcd_pkg::CH_W'(ppm_cnt_reg);
                end
            end
        end
        else if (pwm_cap)
        begin
            if (!phase_reg[port_idx])
            begin
                // Rising edge: remember the time and arm for the falling edge.
                rise_wr              = 1'b1;
                phase_next[port_idx] = 1'b1;
                out_next.arm_falling = 1'b1;
            end
            else
            begin
                // Falling edge: the width is kept if it is inside the window.
                phase_next[port_idx] = 1'b0;
                if (in_window && port_has_ch)
                begin
                    wr_en                 = 1'b1;
                    out_next.stored       = 1'b1;
                    out_next.stored_index = in_reg.port;
                end
            end
        end
    end

    // Control state of the decoder and the channel store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            ppm_cnt_reg   <= '0;
            phase_reg     <= '0;
            for (int i = 0; i < rcd_pkg::NUM_CHANNELS; i++)
            begin
                width_reg[i] <= '0;
            end
        end
        else if (advance && is_capture)
        begin
            if (ppm_cap)
            begin
                prev_time_reg <= in_reg.timestamp;
            end
            ppm_cnt_reg <= ppm_cnt_next;
            phase_reg   <= phase_next;
            if (wr_en)
            begin
                width_reg[wr_idx] <= delta;
            end
        end
    end

    // Rise times need no reset: a falling phase is only entered after a write.
    always_ff @(posedge clk)
    begin
        if (advance && rise_wr)
        begin
            rise_reg[port_idx] <= in_reg.timestamp;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // The PPM channel counter saturates at the channel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ppm_cnt_reg <= rcd_pkg::CNT_MAX)
        else $error("PPM channel counter past the channel count");

    // A frame sync result leaves the counter restarted.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_next.frame_sync |=> ppm_cnt_reg == '0)
        else $error("frame sync did not restart the channel counter");

    // A result never reports both a stored width and a sync or an armed edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.stored |-> !out_reg.frame_sync && !out_reg.arm_falling)
        else $error("stored result also flags sync or armed edge");

    // A stored width lands in the store at the reported channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && out_next.stored
        |=> width_reg[$past(wr_idx)] == $past(delta))
        else $error("stored width missing from the channel store");

    // A stalled input transaction stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("input transaction lost while stalled");

endmodule

`default_nettype wire
